/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dta_pkg.sv */
// Types, register codes and constants of the debounced temperature alarm.
package dta_pkg;

    // Milliseconds per second, for the averaging window and its gate.
    localparam int unsigned MS_PER_S = 1000;

    // Dividend width of the shared divider: window in ms fits 26 bits.
    localparam int unsigned DIV_W     = 26;
    localparam int unsigned DIV_STEPS = DIV_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_CURRENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_S    = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_TEMP_LIMIT  = 16'd24229;
    localparam logic [7:0]  RST_DEBOUNCE    = 8'd5;
    localparam logic        RST_USE_CURRENT = 1'b1;
    localparam logic [15:0] RST_SAMPLE_MS   = 16'd200;
    localparam logic [15:0] RST_AVERAGE_S   = 16'd5;

    // Input beat.
    typedef struct packed {
        logic [15:0] temp_code;
        logic [31:0] now_ms;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic        alarm_on;
        logic [15:0] average_code;
        logic        average_updated;
    } out_beat_t;

endpackage

/* hw/rtl/debounced_temperature_alarm.sv */
// Debounced over-temperature alarm with block averaging on raw sensor codes.
//
// One sample beat in, one result beat out. The block is busy while a sample
// is worked on: it takes the beat, runs the shared restoring divider to get
// the block length from the averaging window and sampling period (skipped
// when the sampling period is zero), accumulates, runs the divider again
// when the sample closes a block to renew its average, checks the alarm and
// loads the output register. The divider works one quotient bit per cycle.
// The output register holds a result while the next sample is taken; a
// sample only waits in the finish state if the previous result has not
// yet been taken.
// Configuration writes are always accepted and belong in idle time.

`include "assert_macros.svh"

module debounced_temperature_alarm (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dta_pkg::in_beat_t                   s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output dta_pkg::out_beat_t                  m_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dta_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_ACCUM,
        ST_DIV_AVG,
        ST_CHECK,
        ST_FINISH
    } state_t;

    localparam int unsigned DW = dta_pkg::DIV_W;
    localparam int unsigned SW = dta_pkg::STEP_W;

    // configuration registers
    logic [15:0] temp_limit_reg;
    logic [7:0]  debounce_reg;
    logic        use_current_reg;
    logic [15:0] sample_ms_reg;
    logic [15:0] average_s_reg;

    // sequencer and datapath registers
    state_t      state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [15:0] code_reg, code_next;
    logic [31:0] now_reg, now_next;
    logic [7:0]  n_reg, n_next;
    logic [23:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] avg_reg, avg_next;
    logic        updated_reg, updated_next;
    logic [31:0] last_up_reg, last_up_next;
    logic [31:0] last_down_reg, last_down_next;
    logic [7:0]  over_reg, over_next;
    logic [7:0]  under_reg, under_next;
    logic        alarm_reg, alarm_next;
    logic        m_valid_reg, m_valid_next;
    dta_pkg::out_beat_t m_data_reg, m_data_next;

    // shared divider registers
    logic [DW-1:0] num_reg, num_next;
    logic [15:0]   den_reg, den_next;
    logic [15:0]   rem_reg, rem_next;

    // combinational helpers
    logic [DW-1:0] window_ms;
    logic [17:0]   trial;
    logic [17:0]   diff;
    logic          qbit;
    logic [DW-1:0] quot;
    logic [15:0]   rem_step;
    logic          last_step;
    logic [23:0]   sum_add;
    logic [7:0]   count_inc;
    logic [15:0]   checked;
    logic [31:0]   gate;
    logic          is_over;
    logic [31:0]   elapsed;
    logic [7:0]    cnt_sel;
    logic [7:0]    cnt_inc;
    logic          out_free;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        sat_inc8 = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_limit_reg  <= dta_pkg::RST_TEMP_LIMIT;
            debounce_reg    <= dta_pkg::RST_DEBOUNCE;
            use_current_reg <= dta_pkg::RST_USE_CURRENT;
            sample_ms_reg   <= dta_pkg::RST_SAMPLE_MS;
            average_s_reg   <= dta_pkg::RST_AVERAGE_S;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dta_pkg::REG_TEMP_LIMIT:  temp_limit_reg  <= cfg_data;
                dta_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data[7:0];
                dta_pkg::REG_USE_CURRENT: use_current_reg <= cfg_data[0];
                dta_pkg::REG_SAMPLE_MS:   sample_ms_reg   <= cfg_data;
                dta_pkg::REG_AVERAGE_S:   average_s_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // averaging window in ms: constant multiply, max 65535000
    assign window_ms = {10'd0, average_s_reg} * DW'(dta_pkg::MS_PER_S);

    // one restoring division step: bring down the dividend MSB
    assign trial     = {1'b0, rem_reg, num_reg[DW-1]};
    assign diff      = trial - {2'b00, den_reg};
    assign qbit      = ~diff[17];
    assign rem_step  = qbit ? diff[15:0] : trial[15:0];
    assign quot      = {num_reg[DW-2:0], qbit};
    assign last_step = (step_reg == SW'(dta_pkg::DIV_STEPS - 1));

    // accumulate
    assign sum_add   = sum_reg + {8'd0, code_reg};
    assign count_inc = sat_inc8(count_reg);

    // alarm check, one subtractor shared by both directions
    assign checked  = use_current_reg ? code_reg : avg_reg;
    assign gate     = use_current_reg ? {16'd0, sample_ms_reg} : {6'd0, window_ms};
    assign is_over  = (checked > temp_limit_reg);
    assign elapsed  = now_reg - (is_over ? last_up_reg : last_down_reg);
    assign cnt_sel  = is_over ? over_reg : under_reg;
    assign cnt_inc  = sat_inc8(cnt_sel);
    assign out_free = ~m_valid_reg | m_ready;

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        code_next      = code_reg;
        now_next       = now_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        updated_next   = updated_reg;
        last_up_next   = last_up_reg;
        last_down_next = last_down_reg;
        over_next      = over_reg;
        under_next     = under_reg;
        alarm_next     = alarm_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg & ~m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    code_next = s_data.temp_code;
                    now_next  = s_data.now_ms;
                    num_next  = window_ms;
                    den_next  = sample_ms_reg;
                    rem_next  = 16'd0;
                    step_next = '0;
                    if (sample_ms_reg == 16'd0) begin
                        n_next     = 8'hFF;
                        state_next = ST_ACCUM;
                    end else begin
                        state_next = ST_DIV_N;
                    end
                end
            end
            ST_DIV_N: begin
                num_next  = quot;
                rem_next  = rem_step;
                step_next = step_reg + SW'(1);
                if (last_step) begin
                    // clamp block length to 1..255
                    if (quot == '0)
                        n_next = 8'd1;
                    else if (|quot[DW-1:8])
                        n_next = 8'hFF;
                    else
                        n_next = quot[7:0];
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (count_inc >= n_reg) begin
                    // block closes: divide the sum, restart the block
                    num_next     = {{(DW-24){1'b0}}, sum_add};
                    den_next     = {8'd0, n_reg};
                    rem_next     = 16'd0;
                    step_next    = '0;
                    sum_next     = 24'd0;
                    count_next   = 8'd0;
                    updated_next = 1'b1;
                    state_next   = ST_DIV_AVG;
                end else begin
                    sum_next     = sum_add;
                    count_next   = count_inc;
                    updated_next = 1'b0;
                    state_next   = ST_CHECK;
                end
            end
            ST_DIV_AVG: begin
                num_next  = quot;
                rem_next  = rem_step;
                step_next = step_reg + SW'(1);
                if (last_step) begin
                    avg_next   = (|quot[DW-1:16]) ? 16'hFFFF : quot[15:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (is_over) begin
                    under_next = 8'd0;
                    if (elapsed >= gate) begin
                        last_up_next = now_reg;
                        if (cnt_inc >= debounce_reg) begin
                            over_next  = debounce_reg;
                            alarm_next = 1'b1;
                        end else begin
                            over_next = cnt_inc;
                        end
                    end
                end else begin
                    over_next = 8'd0;
                    if (elapsed >= gate) begin
                        last_down_next = now_reg;
                        if (cnt_inc >= debounce_reg) begin
                            under_next = debounce_reg;
                            alarm_next = 1'b0;
                        end else begin
                            under_next = cnt_inc;
                        end
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // load the result beat once the output register is free
                if (out_free) begin
                    m_data_next.alarm_on        = alarm_reg;
                    m_data_next.average_code    = avg_reg;
                    m_data_next.average_updated = updated_reg;
                    m_valid_next                = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= 24'd0;
            count_reg     <= 8'd0;
            avg_reg       <= 16'd0;
            updated_reg   <= 1'b0;
            last_up_reg   <= 32'd0;
            last_down_reg <= 32'd0;
            over_reg      <= 8'd0;
            under_reg     <= 8'd0;
            alarm_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            updated_reg   <= updated_next;
            last_up_reg   <= last_up_next;
            last_down_reg <= last_down_next;
            over_reg      <= over_next;
            under_reg     <= under_next;
            alarm_reg     <= alarm_next;
            m_valid_reg   <= m_valid_next;
        end
        code_reg   <= code_next;
        now_reg    <= now_next;
        n_reg      <= n_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    // checks
    `ASSERT_IMPLIES(a_counts_exclusive, aclk, aresetn, over_reg != 8'd0, under_reg == 8'd0, "over and under counters both nonzero")
    `ASSERT_NEXT(a_beat_starts_work, aclk, aresetn, s_valid && s_ready, state_reg == ST_DIV_N || state_reg == ST_ACCUM, "accepted beat did not start work")
    `ASSERT_NEXT(a_finish_loads_out, aclk, aresetn, state_reg == ST_FINISH && out_free, m_valid_reg && state_reg == ST_IDLE, "result beat not loaded at finish")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the debounced temperature alarm: directed script, then random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dta_pkg::*;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_AVERAGE_S + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    localparam int unsigned BLOCK_MAX        = 255;
    localparam int unsigned RANDOM_PHASES    = 16;
    localparam int unsigned SATURATE_PHASE   = 3;
    localparam int unsigned PHASE_ITEMS      = 70;
    localparam int unsigned SATURATE_ITEMS   = 300;
    localparam int unsigned LONG_HOLD_AT     = 400;
    localparam int unsigned LONG_HOLD_CYCLES = 500;
    localparam int unsigned REPORT_LIMIT     = 10;

    localparam out_beat_t ALARM_QUIET  = '{alarm_on: 1'b0, average_code: 16'h0, average_updated: 1'b0};
    localparam out_beat_t ALARM_RAISED = '{alarm_on: 1'b1, average_code: 16'h0, average_updated: 1'b0};
    localparam out_beat_t NO_CHECK     = '0;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          value;   // register data or temperature code
        logic [31:0]          stamp;
        logic                 typed;   // want holds the result read off by hand
        out_beat_t            want;
    } script_row_t;

    localparam int SCRIPT_LEN = 36;

    // Directed script: extremes, zero periods, debounce corners, block cut short, wrap
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'h0000, 32'h0000_0000, 1'b1, ALARM_QUIET},
        '{ROW_WRITE,  REG_DEBOUNCE,    16'h0000, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_SAMPLE_MS,   16'h0000, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ALARM_RAISED},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'h0000, 32'h0000_0000, 1'b1, ALARM_QUIET},
        '{ROW_WRITE,  REG_SPARE_FIRST, 16'hFFFF, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_SPARE_LAST,  16'h5A5A, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_TEMP_LIMIT,  16'h0000, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'h0001, 32'h0000_0005, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'h0000, 32'h0000_0006, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_TEMP_LIMIT,  16'hFFFF, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'hFFFF, 32'h0000_0007, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_DEBOUNCE,    16'hFF0A, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_TEMP_LIMIT,  16'd100,  32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd200,  32'h0000_0008, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd200,  32'h0000_0009, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd200,  32'h0000_000A, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd200,  32'h0000_000B, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_DEBOUNCE,    16'h0002, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd200,  32'h0000_000C, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_SAMPLE_MS,   16'hFFFF, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_AVERAGE_S,   16'h0001, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'hFFFF, 32'h0000_000D, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'h0000, 32'h0000_000E, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_USE_CURRENT, 16'hFFFE, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_AVERAGE_S,   16'h0000, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd500,  32'h0000_000F, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd500,  32'h0000_0010, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd0,    32'h0000_0011, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd0,    32'h0000_0012, 1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_USE_CURRENT, 16'h0001, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_SAMPLE_MS,   16'd1000, 32'h0,         1'b0, NO_CHECK},
        '{ROW_WRITE,  REG_DEBOUNCE,    16'h0001, 32'h0,         1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd500,  32'hFFFF_FF00, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd500,  32'h0000_0100, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, REG_TEMP_LIMIT,  16'd500,  32'h0000_0400, 1'b0, NO_CHECK}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    debounced_temperature_alarm u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Alarm predictor: registers and state, at reset values
    logic [15:0] limit_q    = RST_TEMP_LIMIT;
    logic [7:0]  debounce_q = RST_DEBOUNCE;
    logic        current_q  = RST_USE_CURRENT;
    logic [15:0] period_q   = RST_SAMPLE_MS;
    logic [15:0] window_q   = RST_AVERAGE_S;
    logic [23:0] sum_q      = '0;
    logic [7:0]  count_q    = '0;
    logic [15:0] average_q  = '0;
    logic [31:0] up_time_q  = '0;
    logic [31:0] down_time_q = '0;
    logic [7:0]  over_q     = '0;
    logic [7:0]  under_q    = '0;
    logic        alarm_q    = 1'b0;

    out_beat_t   expected_results [$];
    int unsigned results_seen  = 0;
    int unsigned failures      = 0;
    int unsigned tx_idle_odds  = 4;
    int unsigned rx_idle_odds  = 4;
    int unsigned hold_left     = 0;
    bit          long_hold_done = 1'b0;

    function automatic void note_failure(string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", what);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
        case (index)
            REG_TEMP_LIMIT:  limit_q    = value;
            REG_DEBOUNCE:    debounce_q = value[7:0];
            REG_USE_CURRENT: current_q  = value[0];
            REG_SAMPLE_MS:   period_q   = value;
            REG_AVERAGE_S:   window_q   = value;
            default: ;
        endcase
    endfunction

    // One sample through averaging and the debounced comparison
    function automatic out_beat_t predict_alarm(in_beat_t b);
        int unsigned block_len;
        int unsigned quotient;
        logic [31:0] checked;
        logic [31:0] gate;
        out_beat_t   r;
        // block length: window in ms over sample period, clamped
        if (period_q == 0) begin
            block_len = BLOCK_MAX;
        end else begin
            block_len = (32'(window_q) * MS_PER_S) / period_q;
            if (block_len < 1) block_len = 1;
            if (block_len > BLOCK_MAX) block_len = BLOCK_MAX;
        end
        r.average_updated = 1'b0;
        sum_q   = sum_q + b.temp_code;
        count_q = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
        if (count_q >= block_len) begin
            quotient  = sum_q / block_len;
            average_q = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[15:0];
            sum_q     = '0;
            count_q   = '0;
            r.average_updated = 1'b1;
        end
        checked = current_q ? 32'(b.temp_code) : 32'(average_q);
        gate    = current_q ? 32'(period_q) : 32'(window_q) * MS_PER_S;
        // over and under counters, each gated on elapsed time
        if (checked > limit_q) begin
            under_q = '0;
            if (b.now_ms - up_time_q >= gate) begin
                up_time_q = b.now_ms;
                over_q = (over_q == 8'hFF) ? over_q : over_q + 8'd1;
                if (over_q >= debounce_q) begin
                    over_q  = debounce_q;
                    alarm_q = 1'b1;
                end
            end
        end else begin
            over_q = '0;
            if (b.now_ms - down_time_q >= gate) begin
                down_time_q = b.now_ms;
                under_q = (under_q == 8'hFF) ? under_q : under_q + 8'd1;
                if (under_q >= debounce_q) begin
                    under_q = debounce_q;
                    alarm_q = 1'b0;
                end
            end
        end
        r.alarm_on     = alarm_q;
        r.average_code = average_q;
        return r;
    endfunction

    // Offer one sample beat; queue its expected result once taken
    task automatic send_sample(input in_beat_t b, input logic typed, input out_beat_t want);
        out_beat_t predicted;
        if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_alarm(b);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: check each beat taken, then pick the next ready level
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.alarm_on !== want.alarm_on)
                        note_failure($sformatf("result %0d alarm_on: expected %0h, got %0h",
                                               results_seen, want.alarm_on, m_data.alarm_on));
                    if (m_data.average_code !== want.average_code)
                        note_failure($sformatf("result %0d average_code: expected %0h, got %0h",
                                               results_seen, want.average_code,
                                               m_data.average_code));
                    if (m_data.average_updated !== want.average_updated)
                        note_failure($sformatf("result %0d average_updated: expected %0h, got %0h",
                                               results_seen, want.average_updated,
                                               m_data.average_updated));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                // long back-pressure so the block fills and stalls its input
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (rx_idle_odds != 0 && $urandom_range(1, rx_idle_odds) == 1) begin
                hold_left = $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("debounced_temperature_alarm: mismatch");
        $finish;
    end

    // Stimulus
    initial begin
        in_beat_t    beat;
        logic [15:0] limit;
        logic [15:0] period;
        logic [15:0] window;
        logic [7:0]  debounce;
        logic        use_current;
        logic        hot;
        logic [31:0] clock_ms;
        int unsigned count;
        int unsigned base;
        int          temp;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                drain();
                write_register(script[i].index, script[i].value);
            end else begin
                beat.temp_code = script[i].value;
                beat.now_ms    = script[i].stamp;
                send_sample(beat, script[i].typed, script[i].want);
            end
        end

        // random phases, each with its own register settings
        clock_ms = '0;
        hot      = 1'b0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            if (ph == SATURATE_PHASE) begin
                // long run of over readings with the gate always open: counter pins at 255
                limit       = 16'($urandom_range(0, 1000));
                debounce    = 8'hFF;
                use_current = 1'b1;
                period      = 16'h0000;
                window      = 16'($urandom_range(0, 65535));
                hot         = 1'b1;
            end else begin
                limit = 16'($urandom_range(2000, 62000));
                if ($urandom_range(0, 7) == 0)
                    limit = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                debounce = 8'($urandom_range(0, 6));
                if ($urandom_range(0, 9) == 0)
                    debounce = 8'hFF;
                use_current = 1'($urandom_range(0, 1));
                period = 16'($urandom_range(use_current ? 100 : 500, 1500));
                case ($urandom_range(0, 9))
                    0: period = 16'h0000;
                    1: period = 16'h0001;
                    2: period = 16'hFFFF;
                    default: ;
                endcase
                window = 16'($urandom_range(0, 2));
                if ($urandom_range(0, 9) == 0)
                    window = 16'hFFFF;
            end
            write_register(REG_TEMP_LIMIT, limit);
            write_register(REG_DEBOUNCE, {8'($urandom), debounce});
            write_register(REG_USE_CURRENT, {15'($urandom), use_current});
            write_register(REG_SAMPLE_MS, period);
            write_register(REG_AVERAGE_S, window);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                               16'($urandom));

            // no idling at all in the closing phase
            if (ph == RANDOM_PHASES - 1) begin
                tx_idle_odds = 0;
                rx_idle_odds = 0;
            end else begin
                tx_idle_odds = $urandom_range(0, 3) * 3;
                rx_idle_odds = $urandom_range(0, 3) * 4;
            end
            if ($urandom_range(0, 2) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            base  = period;
            count = (ph == SATURATE_PHASE) ? SATURATE_ITEMS : PHASE_ITEMS;

            repeat (count) begin
                if (ph % 5 == 4) begin
                    // noise: any code, any timestamp
                    beat.temp_code = 16'($urandom);
                    beat.now_ms    = $urandom();
                end else begin
                    // excursions above and below the limit at roughly the sample period
                    if (ph != SATURATE_PHASE && $urandom_range(0, 11) == 0)
                        hot = !hot;
                    temp = int'(limit);
                    if (hot)
                        temp += $urandom_range(1, 3000);
                    else
                        temp -= $urandom_range(0, 3000);
                    if (temp < 0) temp = 0;
                    if (temp > 65535) temp = 65535;
                    if ($urandom_range(0, 15) != 0)
                        clock_ms += (base == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(base - base / 4, base + base / 4);
                    beat.temp_code = 16'(temp);
                    beat.now_ms    = clock_ms;
                end
                send_sample(beat, 1'b0, NO_CHECK);
            end
        end

        drain();
        repeat (60) @(posedge aclk);
        if (failures == 0 && expected_results.size() == 0)
            $display("debounced_temperature_alarm: match");
        else
            $display("debounced_temperature_alarm: mismatch");
        $finish;
    end

endmodule

/* debounced_temperature_alarm.f */
+incdir+hw/rtl
hw/rtl/dta_pkg.sv
hw/rtl/debounced_temperature_alarm.sv
tb/sv/tb.sv
